### rtl/core/sfr_pkg.sv
// Shared types and constants for the stream find-and-replace block.
// No dependencies; imported by the window store and the top level.
package sfr_pkg;

    // Default size limits
    localparam int SFR_MAX_PATTERN     = 8;
    localparam int SFR_MAX_REPLACEMENT = 8;

    // Configuration port geometry and register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LEN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_BYTES = 2'd3;

    // Byte emitted at every line end
    localparam logic [7:0] NEWLINE_BYTE = 8'd10;

    // Input transfer payload
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_line;
    } t_in_item;

    // Output transfer payload
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_out_item;

    // Window store commands from the sequencer
    typedef struct packed {
        logic       append;
        logic       shift;
        logic       clear;
        logic [7:0] wr_byte;
    } t_win_ctl;

endpackage

### rtl/core/sfr_window.sv
// Pending-byte window: a short FIFO of bytes that may still start a match.
// Depends on sfr_pkg for the command struct.
module sfr_window
    import sfr_pkg::*;
#(
    parameter int DEPTH = SFR_MAX_PATTERN,
    localparam int CW = $clog2(DEPTH + 1),
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_win_ctl      i_ctl,
    input  logic [IW-1:0] i_rd_idx,
    output logic [7:0]    o_rd_byte,
    output logic [7:0]    o_front,
    output logic [CW-1:0] o_count
);

    logic [7:0]    r_ent [DEPTH];
    logic [CW-1:0] r_count;
    logic          room;

    assign room = (r_count < CW'(DEPTH));

    // Track the fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.clear) begin
            r_count <= '0;
        end else if (i_ctl.shift) begin
            r_count <= r_count - CW'(1);
        end else if (i_ctl.append && room) begin
            r_count <= r_count + CW'(1);
        end
    end

    // Drop the front entry or write at the tail
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                r_ent[i] <= r_ent[i + 1];
            end
        end else if (i_ctl.append && room) begin
            r_ent[r_count[IW-1:0]] <= i_ctl.wr_byte;
        end
    end

    assign o_rd_byte = r_ent[i_rd_idx];
    assign o_front   = r_ent[0];
    assign o_count   = r_count;

endmodule

### rtl/core/stream_find_and_replace_unit.sv
// Stream find-and-replace top level: config registers, sequencer, output stage.
// Depends on sfr_pkg and sfr_window.
//
// One byte of a text line enters per input transfer; every leftmost,
// non-overlapping occurrence of the configured pattern is replaced and a
// newline closes each line. The block takes one item at a time and holds
// o_in_stall high until the item's last result is pushed to the output
// register. A single byte comparator checks the pending window one byte per
// cycle. An item is accepted, then checked against the pattern after the
// append and again after every released byte; it emits its released or
// replacement bytes, and at a line end flushes the window and emits the
// newline before a closing state. Output transfers that stall hold it back.
// A result is staged one byte behind so that the final result of each item
// can carry last_of_run.
module stream_find_and_replace_unit
    import sfr_pkg::*;
#(
    parameter int MAX_PATTERN     = SFR_MAX_PATTERN,
    parameter int MAX_REPLACEMENT = SFR_MAX_REPLACEMENT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item
);

    localparam int CW  = $clog2(MAX_PATTERN + 1);
    localparam int IW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int RW  = $clog2(MAX_REPLACEMENT + 1);
    localparam int RIW = (MAX_REPLACEMENT > 1) ? $clog2(MAX_REPLACEMENT) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RELEASE,
        S_REPL,
        S_FLUSH,
        S_NEWLINE,
        S_DONE
    } t_state;

    // Configuration registers
    logic [3:0]  r_plen;
    logic [63:0] r_pat;
    logic [3:0]  r_rlen;
    logic [63:0] r_rep;

    // Sequencer registers
    t_state        r_state, n_state;
    logic [CW-1:0] r_k, n_k;
    logic [RW-1:0] r_j, n_j;
    logic          r_eol, n_eol;
    logic          r_fresh, n_fresh;
    logic [7:0]    r_hold, n_hold;
    logic          r_hold_v, n_hold_v;
    t_out_item     r_out, n_out;
    logic          r_out_valid, n_out_valid;

    // Window interface
    t_win_ctl      win_ctl;
    logic [7:0]    win_rd;
    logic [7:0]    win_front;
    logic [CW-1:0] win_count;

    // Clamped lengths and derived compare terms
    logic [3:0]    plen;
    logic [RW-1:0] rlen;
    logic [3:0]    cnt4;
    logic [7:0]    pat_k;
    logic [7:0]    rep_j;
    logic          chk_over, chk_end, chk_miss, chk_prefix;
    logic          is_match, keep;
    logic          out_free, can_emit, emit_req, push;
    logic [7:0]    emit_byte;
    logic          push_last;
    logic          in_xfer;

    assign plen = (r_plen > 4'(MAX_PATTERN)) ? 4'(MAX_PATTERN) : r_plen;
    assign rlen = (r_rlen > 4'(MAX_REPLACEMENT)) ? RW'(MAX_REPLACEMENT) : r_rlen[RW-1:0];
    assign cnt4 = 4'(win_count);

    assign pat_k = r_pat[{r_k[IW-1:0], 3'b000} +: 8];
    assign rep_j = r_rep[{r_j[RIW-1:0], 3'b000} +: 8];

    // Shared byte comparator: one window entry per cycle
    assign chk_over   = (cnt4 > plen);
    assign chk_end    = (r_k == win_count);
    assign chk_miss   = (win_rd != pat_k);
    assign chk_prefix = !chk_over && chk_end;
    // A match is only taken on the check right after the append
    assign is_match   = r_fresh && (plen != 4'd0) && (cnt4 == plen) && chk_prefix;
    assign keep       = (win_count == '0) || ((cnt4 < plen) && chk_prefix);

    assign out_free   = !r_out_valid || !i_out_stall;
    assign can_emit   = !r_hold_v || out_free;
    assign in_xfer    = i_in_valid && !o_in_stall;

    sfr_window #(
        .DEPTH (MAX_PATTERN)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (win_ctl),
        .i_rd_idx  (r_k[IW-1:0]),
        .o_rd_byte (win_rd),
        .o_front   (win_front),
        .o_count   (win_count)
    );

    // Sequence one item: check, release, replace, flush, newline, done
    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_j       = r_j;
        n_eol     = r_eol;
        n_fresh   = r_fresh;
        win_ctl   = '0;
        emit_req  = 1'b0;
        emit_byte = win_front;
        push_last = 1'b0;

        win_ctl.wr_byte = i_in_item.data_byte;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_eol   = i_in_item.end_of_line;
                    n_k     = '0;
                    n_fresh = 1'b1;
                    if (i_in_item.byte_present) begin
                        win_ctl.append = 1'b1;
                        n_state        = S_CHECK;
                    end else if (i_in_item.end_of_line) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_CHECK: begin
                if (chk_over || chk_end || chk_miss) begin
                    if (is_match) begin
                        win_ctl.clear = 1'b1;
                        n_j           = '0;
                        if (rlen != '0) begin
                            n_state = S_REPL;
                        end else begin
                            n_state = r_eol ? S_FLUSH : S_DONE;
                        end
                    end else if (!keep) begin
                        n_state = S_RELEASE;
                    end else begin
                        n_state = r_eol ? S_FLUSH : S_DONE;
                    end
                end else begin
                    n_k = r_k + CW'(1);
                end
            end
            S_RELEASE: begin
                emit_req = 1'b1;
                if (can_emit) begin
                    win_ctl.shift = 1'b1;
                    n_k           = '0;
                    n_fresh       = 1'b0;
                    n_state       = S_CHECK;
                end
            end
            S_REPL: begin
                emit_req  = 1'b1;
                emit_byte = rep_j;
                if (can_emit) begin
                    n_j = r_j + RW'(1);
                    if (r_j + RW'(1) == rlen) begin
                        n_state = r_eol ? S_FLUSH : S_DONE;
                    end
                end
            end
            S_FLUSH: begin
                if (win_count == '0) begin
                    n_state = S_NEWLINE;
                end else begin
                    emit_req = 1'b1;
                    if (can_emit) begin
                        win_ctl.shift = 1'b1;
                    end
                end
            end
            S_NEWLINE: begin
                emit_req  = 1'b1;
                emit_byte = NEWLINE_BYTE;
                if (can_emit) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_hold_v) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    push_last = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Stage each byte one behind; push the staged byte as a non-final result, or as the final one on push_last
    always_comb begin
        n_hold      = r_hold;
        n_hold_v    = r_hold_v;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        push        = 1'b0;

        if (emit_req && can_emit) begin
            push     = r_hold_v;
            n_hold   = emit_byte;
            n_hold_v = 1'b1;
        end else if (push_last) begin
            push     = 1'b1;
            n_hold_v = 1'b0;
        end

        if (push) begin
            n_out.out_byte    = r_hold;
            n_out.last_of_run = push_last;
            n_out_valid       = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // Hold state, configuration and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hold_v    <= 1'b0;
            r_out_valid <= 1'b0;
            r_plen      <= '0;
            r_pat       <= '0;
            r_rlen      <= '0;
            r_rep       <= '0;
        end else begin
            r_state     <= n_state;
            r_hold_v    <= n_hold_v;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PATTERN_LEN:       r_plen <= i_cfg_data[3:0];
                    CFG_PATTERN_BYTES:     r_pat  <= i_cfg_data;
                    CFG_REPLACEMENT_LEN:   r_rlen <= i_cfg_data[3:0];
                    CFG_REPLACEMENT_BYTES: r_rep  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        r_k     <= n_k;
        r_j     <= n_j;
        r_eol   <= n_eol;
        r_fresh <= n_fresh;
        r_hold  <= n_hold;
        r_out   <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Window never holds more than MAX_PATTERN bytes
    a_win_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        win_count <= CW'(MAX_PATTERN))
        else $error("window fill beyond pattern limit");

    // Staging slot is empty whenever a new item may enter
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_hold_v)
        else $error("staged byte left over at idle");

    // A push never overwrites a result still waiting downstream
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (!r_out_valid || !i_out_stall))
        else $error("output register overwritten");

    // Replacement bytes go out only after the matched window was dropped
    a_repl_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REPL) |-> (win_count == '0))
        else $error("replacement with bytes pending");

    // An item with neither byte nor line end leaves the block idle
    a_empty_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && !i_in_item.byte_present && !i_in_item.end_of_line)
            |=> (r_state == S_IDLE))
        else $error("empty item started work");

endmodule

### verif/testbench.sv
// Self-checking testbench for stream_find_and_replace_unit: directed table, then random lines.
// Depends on sfr_pkg and the RTL under rtl/core; results are checked against an in-bench predictor or typed-in rows.
module testbench;
    import sfr_pkg::*;

    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_ITEMS  = 400;
    localparam int QUIET_AFTER   = 350;
    localparam int LONG_HOLD     = 300;
    localparam int WIN_DEPTH     = SFR_MAX_PATTERN + 1;

    // One row of the directed stimulus: a register write or an input transfer
    typedef struct packed {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        t_in_item              item;
        bit                    typed;
        logic [1:0]            n_typed;
        logic [7:0]            b0;
        logic [7:0]            b1;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_item              i_in_item;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_item;

    // Predictor copy of the registers and the pending window
    logic [3:0]  pat_len_q = '0;
    logic [63:0] pat_q     = '0;
    logic [3:0]  rep_len_q = '0;
    logic [63:0] rep_q     = '0;
    logic [7:0]  win_q [WIN_DEPTH];
    int          win_cnt = 0;

    t_out_item   item_results [$];
    t_out_item   expected_bytes [$];
    int          rand_items = 0;
    bit          in_random  = 0;
    bit          quiet_tail = 0;
    bit          failed     = 0;

    stream_find_and_replace_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    function automatic int clamp_len(logic [3:0] v, int lim);
        return (int'(v) > lim) ? lim : int'(v);
    endfunction

    function automatic bit window_is_pattern_prefix(int plen);
        if (win_cnt > plen) return 1'b0;
        for (int k = 0; k < win_cnt; k++)
            if (win_q[k] != pat_q[8*k +: 8]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void emit_byte(logic [7:0] b);
        t_out_item r;
        r.out_byte    = b;
        r.last_of_run = 1'b0;
        item_results.push_back(r);
    endfunction

    // Advance the window by one input item and collect the bytes it produces
    function automatic void step_line_window(t_in_item it);
        int plen;
        int rlen;
        plen = clamp_len(pat_len_q, SFR_MAX_PATTERN);
        rlen = clamp_len(rep_len_q, SFR_MAX_REPLACEMENT);
        item_results.delete();
        if (it.byte_present) begin
            if (win_cnt < WIN_DEPTH) begin
                win_q[win_cnt] = it.data_byte;
                win_cnt++;
            end
            if (plen > 0 && win_cnt == plen && window_is_pattern_prefix(plen)) begin
                for (int k = 0; k < rlen; k++) emit_byte(rep_q[8*k +: 8]);
                win_cnt = 0;
            end else begin
                // release from the front until the window is a proper prefix again
                while (win_cnt > 0 && !(win_cnt < plen && window_is_pattern_prefix(plen))) begin
                    emit_byte(win_q[0]);
                    for (int k = 1; k < win_cnt; k++) win_q[k-1] = win_q[k];
                    win_cnt--;
                end
            end
        end
        if (it.end_of_line) begin
            for (int k = 0; k < win_cnt; k++) emit_byte(win_q[k]);
            win_cnt = 0;
            emit_byte(NEWLINE_BYTE);
        end
        if (item_results.size() > 0) item_results[item_results.size()-1].last_of_run = 1'b1;
    endfunction

    function automatic t_stim_row cfg_row(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
        t_stim_row r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        return r;
    endfunction

    function automatic t_stim_row byte_row(bit p, logic [7:0] d, bit e);
        t_stim_row r;
        r                   = '0;
        r.item.data_byte    = d;
        r.item.byte_present = p;
        r.item.end_of_line  = e;
        return r;
    endfunction

    // Row whose results are typed in by hand
    function automatic t_stim_row known_row(bit p, logic [7:0] d, bit e, int n,
                                           logic [7:0] b0, logic [7:0] b1);
        t_stim_row r;
        r         = byte_row(p, d, e);
        r.typed   = 1'b1;
        r.n_typed = n[1:0];
        r.b0      = b0;
        r.b1      = b1;
        return r;
    endfunction

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_PATTERN_LEN:       pat_len_q = data[3:0];
            CFG_PATTERN_BYTES:     pat_q     = data;
            CFG_REPLACEMENT_LEN:   rep_len_q = data[3:0];
            CFG_REPLACEMENT_BYTES: rep_q     = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Offer one item, hold it until the transfer, then queue what it should produce
    task automatic send_item(t_in_item it, bit typed, int n_typed,
                             logic [7:0] b0, logic [7:0] b1);
        t_out_item r;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        step_line_window(it);
        if (typed) begin
            for (int k = 0; k < n_typed; k++) begin
                r.out_byte    = (k == 0) ? b0 : b1;
                r.last_of_run = (k == n_typed - 1);
                expected_bytes.push_back(r);
            end
        end else begin
            foreach (item_results[k]) expected_bytes.push_back(item_results[k]);
        end
    endtask

    task automatic hold_off_sender(int pct);
        int n;
        if (!quiet_tail && $urandom_range(0, 99) < pct) begin
            n = $urandom_range(1, 5);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // Drain all expected results, then let the block finish any silent work
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Check each output transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected result: expected none, got byte %02h last %0b",
                         $time, o_out_item.out_byte, o_out_item.last_of_run);
                failed = 1'b1;
            end else begin
                want = expected_bytes.pop_front();
                if (o_out_item.out_byte !== want.out_byte) begin
                    $display("%0t: out_byte mismatch: expected %02h, got %02h",
                             $time, want.out_byte, o_out_item.out_byte);
                    failed = 1'b1;
                end
                if (o_out_item.last_of_run !== want.last_of_run) begin
                    $display("%0t: last_of_run mismatch: expected %0b, got %0b",
                             $time, want.last_of_run, o_out_item.last_of_run);
                    failed = 1'b1;
                end
            end
        end
    end

    // Receiver: random stall bursts, calm stretches and one long hold-off
    initial begin : out_stall_ctl
        int  burst_left;
        int  calm_left;
        int  hold_left;
        int  r;
        bit  held_once;
        bit  stall_now;
        burst_left = 0;
        calm_left  = 0;
        hold_left  = 0;
        held_once  = 0;
        forever begin
            @(negedge i_clk);
            if (!held_once && in_random && rand_items >= 60) begin
                held_once = 1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                stall_now = 1'b1;
                hold_left--;
            end else if (quiet_tail) begin
                stall_now = 1'b0;
            end else if (burst_left > 0) begin
                stall_now = 1'b1;
                burst_left--;
            end else if (calm_left > 0) begin
                stall_now = 1'b0;
                calm_left--;
            end else begin
                r = $urandom_range(0, 99);
                stall_now = 1'b0;
                if (r < 25) begin
                    stall_now  = 1'b1;
                    burst_left = $urandom_range(0, 4);
                end else if (r < 30) begin
                    calm_left = $urandom_range(10, 60);
                end
            end
            i_out_stall <= stall_now;
        end
    end

    initial begin : stimulus
        t_stim_row   dir_tab [$];
        t_in_item    it;
        logic [7:0]  feed [$];
        logic [63:0] wd;
        logic [7:0]  s0;
        logic [7:0]  s1;
        int          plen;
        int          r;
        int          cut;
        int          n_phase;
        int          gap_pct;
        bit          was_item;

        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_item  = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        dir_tab = '{
            // pass-through after reset: byte extremes, bare line end, empty item
            known_row(1, 8'h00, 0, 1, 8'h00, 8'h00),
            known_row(1, 8'hFF, 1, 2, 8'hFF, NEWLINE_BYTE),
            known_row(0, 8'hA5, 1, 1, NEWLINE_BYTE, 8'h00),
            known_row(0, 8'h5A, 0, 0, 8'h00, 8'h00),
            // pattern "abc" -> "XY"
            cfg_row(CFG_PATTERN_BYTES, 64'h636261),
            cfg_row(CFG_REPLACEMENT_BYTES, 64'h5958),
            cfg_row(CFG_PATTERN_LEN, 64'd3),
            cfg_row(CFG_REPLACEMENT_LEN, 64'd2),
            known_row(1, 8'h61, 0, 0, 8'h00, 8'h00),
            known_row(1, 8'h62, 0, 0, 8'h00, 8'h00),
            known_row(1, 8'h63, 0, 2, 8'h58, 8'h59),
            // partial match that breaks: "aab" then 'x' with line end
            byte_row(1, 8'h61, 0),
            byte_row(1, 8'h61, 0),
            byte_row(1, 8'h62, 0),
            byte_row(1, 8'h78, 1),
            // shorten the pattern while "ab" is pending
            byte_row(1, 8'h61, 0),
            byte_row(1, 8'h62, 0),
            cfg_row(CFG_PATTERN_LEN, 64'd2),
            byte_row(1, 8'h61, 0),
            byte_row(1, 8'h62, 1),
            // lengths above the limit, zero bytes in the pattern, full replacement
            cfg_row(CFG_PATTERN_BYTES, 64'h00FF_0000_FF00_0000),
            cfg_row(CFG_REPLACEMENT_BYTES, 64'h8877_6655_4433_2211),
            cfg_row(CFG_PATTERN_LEN, 64'hFFFF_FFFF_FFFF_FFFF),
            cfg_row(CFG_REPLACEMENT_LEN, 64'hFFFF_FFFF_FFFF_FFF9),
            byte_row(1, 8'h00, 0),
            byte_row(1, 8'h00, 0),
            byte_row(1, 8'h00, 0),
            byte_row(1, 8'hFF, 0),
            byte_row(1, 8'h00, 0),
            byte_row(1, 8'h00, 0),
            byte_row(1, 8'hFF, 0),
            byte_row(1, 8'h00, 1),
            // empty replacement deletes each match
            cfg_row(CFG_PATTERN_BYTES, 64'h78),
            cfg_row(CFG_PATTERN_LEN, 64'd1),
            cfg_row(CFG_REPLACEMENT_LEN, 64'd0),
            known_row(1, 8'h78, 0, 0, 8'h00, 8'h00),
            known_row(1, 8'h78, 1, 1, NEWLINE_BYTE, 8'h00)
        };

        // Walk the directed table
        was_item = 1'b1;
        foreach (dir_tab[i]) begin
            if (dir_tab[i].is_cfg) begin
                if (was_item) wait_idle();
                cfg_write(dir_tab[i].idx, dir_tab[i].data);
                was_item = 1'b0;
            end else begin
                send_item(dir_tab[i].item, dir_tab[i].typed, int'(dir_tab[i].n_typed),
                          dir_tab[i].b0, dir_tab[i].b1);
                hold_off_sender(30);
                was_item = 1'b1;
            end
        end

        // Random phases: new settings, then lines built mostly from the pattern
        in_random = 1'b1;
        while (rand_items < RANDOM_ITEMS) begin
            wait_idle();
            if ($urandom_range(0, 1)) begin
                wd = {$urandom, $urandom};
            end else begin
                s0 = 8'($urandom_range(0, 255));
                s1 = 8'($urandom_range(0, 255));
                for (int k = 0; k < 8; k++) wd[8*k +: 8] = $urandom_range(0, 1) ? s1 : s0;
            end
            cfg_write(CFG_PATTERN_BYTES, wd);
            cfg_write(CFG_REPLACEMENT_BYTES, {$urandom, $urandom});
            r  = $urandom_range(0, 99);
            wd = {$urandom, $urandom};
            wd[3:0] = (r < 6) ? 4'd0 : (r < 14) ? 4'($urandom_range(9, 15))
                                                : 4'($urandom_range(1, 8));
            cfg_write(CFG_PATTERN_LEN, wd);
            r  = $urandom_range(0, 99);
            wd = {$urandom, $urandom};
            wd[3:0] = (r < 10) ? 4'd0 : (r < 18) ? 4'($urandom_range(9, 15))
                                                 : 4'($urandom_range(1, 8));
            cfg_write(CFG_REPLACEMENT_LEN, wd);

            feed.delete();
            plen    = clamp_len(pat_len_q, SFR_MAX_PATTERN);
            gap_pct = $urandom_range(0, 1) ? 30 : 0;
            n_phase = $urandom_range(20, 50);
            repeat (n_phase) begin
                // refill the byte source: whole pattern, a prefix, or single bytes
                if (feed.size() == 0) begin
                    r = $urandom_range(0, 99);
                    if (plen == 0 || r < 10) begin
                        feed.push_back(8'($urandom_range(0, 255)));
                    end else if (r < 50) begin
                        for (int k = 0; k < plen; k++) feed.push_back(pat_q[8*k +: 8]);
                    end else if (r < 70) begin
                        cut = $urandom_range(1, plen);
                        for (int k = 0; k < cut; k++) feed.push_back(pat_q[8*k +: 8]);
                    end else begin
                        cut = $urandom_range(0, plen - 1);
                        feed.push_back(pat_q[8*cut +: 8]);
                    end
                end
                r            = $urandom_range(0, 99);
                it.data_byte = 8'($urandom_range(0, 255));
                if (r < 4) begin
                    it.byte_present = 1'b0;
                    it.end_of_line  = 1'b0;
                end else if (r < 9) begin
                    it.byte_present = 1'b0;
                    it.end_of_line  = 1'b1;
                end else begin
                    it.byte_present = 1'b1;
                    it.data_byte    = feed.pop_front();
                    it.end_of_line  = ($urandom_range(0, 99) < 7);
                end
                send_item(it, 1'b0, 0, 8'h00, 8'h00);
                if (it.byte_present || it.end_of_line) rand_items++;
                quiet_tail = (rand_items >= QUIET_AFTER);
                hold_off_sender(gap_pct);
            end
        end

        wait_idle();
        if (!failed) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Give up if the run hangs
    initial begin : run_limit
        #5000000;
        $display("status: fail");
        $finish;
    end

endmodule

### filelist.f
rtl/core/sfr_pkg.sv
rtl/core/sfr_window.sv
rtl/core/stream_find_and_replace_unit.sv
verif/testbench.sv
